// File: sv/cpu8_rae_pkg.sv
// shared types, opcode classes and decode table for the 8-bit execute unit
`default_nettype none

package cpu8_rae_pkg;

    localparam logic [7:0] SP_RESET     = 8'hfd;
    localparam logic [7:0] STATUS_RESET = 8'h20;

    typedef enum logic [5:0] {
        O_XX, O_NOP, O_ORA, O_AND, O_EOR, O_ADC, O_SBC, O_CMP, O_CPX, O_CPY,
        O_BIT, O_ASL, O_ROL, O_LSR, O_ROR, O_INC, O_DEC, O_LDA, O_LDX, O_LDY,
        O_LAX, O_STA, O_STX, O_STY, O_SAX, O_SLO, O_RLA, O_SRE, O_RRA, O_DCP,
        O_ISB, O_TAX, O_TAY, O_TXA, O_TYA, O_TSX, O_TXS, O_INX, O_INY, O_DEX,
        O_DEY, O_CLC, O_SEC, O_CLI, O_SEI, O_CLV, O_CLD, O_SED
    } op_class_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } regs_t;

    typedef struct packed {
        logic [7:0] store_value;
        logic       store_enable;
        regs_t      regs;
        logic       handled;
    } result_t;

    localparam op_class_t DECODE_TABLE [256] = '{
        O_XX, O_ORA,O_NOP,O_SLO,O_NOP,O_ORA,O_ASL,O_SLO,
        O_XX, O_ORA,O_ASL,O_NOP,O_NOP,O_ORA,O_ASL,O_SLO,
        O_XX, O_ORA,O_NOP,O_SLO,O_NOP,O_ORA,O_ASL,O_SLO,
        O_CLC,O_ORA,O_NOP,O_SLO,O_NOP,O_ORA,O_ASL,O_SLO,
        O_XX, O_AND,O_NOP,O_RLA,O_BIT,O_AND,O_ROL,O_RLA,
        O_XX, O_AND,O_ROL,O_NOP,O_BIT,O_AND,O_ROL,O_RLA,
        O_XX, O_AND,O_NOP,O_RLA,O_NOP,O_AND,O_ROL,O_RLA,
        O_SEC,O_AND,O_NOP,O_RLA,O_NOP,O_AND,O_ROL,O_RLA,
        O_XX, O_EOR,O_NOP,O_SRE,O_NOP,O_EOR,O_LSR,O_SRE,
        O_XX, O_EOR,O_LSR,O_NOP,O_XX, O_EOR,O_LSR,O_SRE,
        O_XX, O_EOR,O_NOP,O_SRE,O_NOP,O_EOR,O_LSR,O_SRE,
        O_CLI,O_EOR,O_NOP,O_SRE,O_NOP,O_EOR,O_LSR,O_SRE,
        O_XX, O_ADC,O_NOP,O_RRA,O_NOP,O_ADC,O_ROR,O_RRA,
        O_XX, O_ADC,O_ROR,O_NOP,O_XX, O_ADC,O_ROR,O_RRA,
        O_XX, O_ADC,O_NOP,O_RRA,O_NOP,O_ADC,O_ROR,O_RRA,
        O_SEI,O_ADC,O_NOP,O_RRA,O_NOP,O_ADC,O_ROR,O_RRA,
        O_NOP,O_STA,O_NOP,O_SAX,O_STY,O_STA,O_STX,O_SAX,
        O_DEY,O_NOP,O_TXA,O_NOP,O_STY,O_STA,O_STX,O_SAX,
        O_XX, O_STA,O_NOP,O_NOP,O_STY,O_STA,O_STX,O_SAX,
        O_TYA,O_STA,O_TXS,O_NOP,O_NOP,O_STA,O_NOP,O_NOP,
        O_LDY,O_LDA,O_LDX,O_LAX,O_LDY,O_LDA,O_LDX,O_LAX,
        O_TAY,O_LDA,O_TAX,O_NOP,O_LDY,O_LDA,O_LDX,O_LAX,
        O_XX, O_LDA,O_NOP,O_LAX,O_LDY,O_LDA,O_LDX,O_LAX,
        O_CLV,O_LDA,O_TSX,O_LAX,O_LDY,O_LDA,O_LDX,O_LAX,
        O_CPY,O_CMP,O_NOP,O_DCP,O_CPY,O_CMP,O_DEC,O_DCP,
        O_INY,O_CMP,O_DEX,O_NOP,O_CPY,O_CMP,O_DEC,O_DCP,
        O_XX, O_CMP,O_NOP,O_DCP,O_NOP,O_CMP,O_DEC,O_DCP,
        O_CLD,O_CMP,O_NOP,O_DCP,O_NOP,O_CMP,O_DEC,O_DCP,
        O_CPX,O_SBC,O_NOP,O_ISB,O_CPX,O_SBC,O_INC,O_ISB,
        O_INX,O_SBC,O_NOP,O_SBC,O_CPX,O_SBC,O_INC,O_ISB,
        O_XX, O_SBC,O_NOP,O_ISB,O_NOP,O_SBC,O_INC,O_ISB,
        O_SED,O_SBC,O_NOP,O_ISB,O_NOP,O_SBC,O_INC,O_ISB
    };

endpackage

`default_nettype wire

// File: sv/cpu8_rae_if.sv
// valid/ready channel interfaces for instruction items and result items
`default_nettype none

interface cpu8_rae_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] op;
    logic [7:0] operand;

    modport source (output valid, output op, output operand, input ready);
    modport sink (input valid, input op, input operand, output ready);
endinterface

interface cpu8_rae_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] store_value;
    logic       store_enable;
    logic [7:0] reg_a;
    logic [7:0] reg_x;
    logic [7:0] reg_y;
    logic [7:0] stack_ptr;
    logic [7:0] status_flags;
    logic       handled;

    modport source (output valid, output store_value, output store_enable, output reg_a,
                    output reg_x, output reg_y, output stack_ptr, output status_flags,
                    output handled, input ready);
    modport sink (input valid, input store_value, input store_enable, input reg_a,
                  input reg_x, input reg_y, input stack_ptr, input status_flags,
                  input handled, output ready);
endinterface

`default_nettype wire

// File: sv/cpu8_rae_alu.sv
// combinational opcode execution: register file in, register file and store out
`default_nettype none

module cpu8_rae_alu
    import cpu8_rae_pkg::*;
(
    input  wire logic [7:0] op,
    input  wire logic [7:0] operand,
    input  wire logic       decimal_enable,
    input  regs_t           regs_in,
    output result_t         result
);

    op_class_t   code;
    logic        mode_a;
    logic [7:0]  a, x, y, sp, p, m, v, r, wv;
    logic        we, rmw, bcd, c, b;
    logic [9:0]  sum;
    logic [15:0] d;

    always_comb
    begin
        code   = DECODE_TABLE[op];
        mode_a = (op[3:0] == 4'h8) || (op[3:0] == 4'ha)
              || ((op[3:0] == 4'h2) && (op[4] || !op[7]))
              || (op == 8'h00) || (op == 8'h40) || (op == 8'h60);
        a   = regs_in.a;
        x   = regs_in.x;
        y   = regs_in.y;
        sp  = regs_in.sp;
        p   = regs_in.p | STATUS_RESET;
        m   = operand;
        we  = 1'b0;
        wv  = 8'h00;
        bcd = p[3] && decimal_enable;
        sum = 10'd0;
        d   = 16'd0;
        c   = 1'b0;
        b   = 1'b0;

        // read-modify-write half
        v   = mode_a ? a : m;
        rmw = 1'b1;
        case (code)
            O_ASL, O_SLO:
            begin
                r = {v[6:0], 1'b0};
                p[0] = v[7];
            end
            O_ROL, O_RLA:
            begin
                r = {v[6:0], p[0]};
                p[0] = v[7];
            end
            O_LSR, O_SRE:
            begin
                r = {1'b0, v[7:1]};
                p[0] = v[0];
            end
            O_ROR, O_RRA:
            begin
                r = {p[0], v[7:1]};
                p[0] = v[0];
            end
            O_INC, O_ISB: r = v + 8'd1;
            O_DEC, O_DCP: r = v - 8'd1;
            default:
            begin
                r   = v;
                rmw = 1'b0;
            end
        endcase
        if (rmw)
        begin
            p[1] = (r == 8'h00);
            p[7] = r[7];
            if (mode_a)
                a = r;
            else
            begin
                m  = r;
                we = 1'b1;
                wv = r;
            end
        end

        // accumulator / register half
        v = mode_a ? a : m;
        case (code)
            O_ORA, O_SLO:
            begin
                a = a | v;
                p[1] = (a == 8'h00);
                p[7] = a[7];
            end
            O_AND, O_RLA:
            begin
                a = a & v;
                p[1] = (a == 8'h00);
                p[7] = a[7];
            end
            O_EOR, O_SRE:
            begin
                a = a ^ v;
                p[1] = (a == 8'h00);
                p[7] = a[7];
            end
            O_ADC, O_RRA:
            begin
                c = p[0];
                sum = {2'b00, v} + {2'b00, a} + {9'd0, c};
                p[1] = (sum[7:0] == 8'h00);
                if (bcd)
                begin
                    if (({1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, c}) > 5'd9)
                        sum = sum + 10'd6;
                    p[7] = sum[7];
                    p[6] = ~(a[7] ^ v[7]) & (a[7] ^ sum[7]);
                    if (sum > 10'h099)
                        sum = sum + 10'h060;
                    p[0] = (sum > 10'h099);
                end
                else
                begin
                    p[7] = sum[7];
                    p[6] = ~(a[7] ^ v[7]) & (a[7] ^ sum[7]);
                    p[0] = sum[8];
                end
                a = sum[7:0];
            end
            O_SBC, O_ISB:
            begin
                b = ~p[0];
                d = {8'h00, a} - {8'h00, v} - {15'd0, b};
                p[1] = (d[7:0] == 8'h00);
                p[7] = d[7];
                p[6] = (a[7] ^ d[7]) & (a[7] ^ v[7]);
                if (bcd)
                begin
                    if ({1'b0, a[3:0]} < ({1'b0, v[3:0]} + {4'd0, b}))
                        d = d - 16'd6;
                    if (d > 16'h0099)
                        d = d - 16'h0060;
                end
                p[0] = (d < 16'h0100);
                a = d[7:0];
            end
            O_CMP, O_DCP:
            begin
                p[0] = (a >= v);
                r = a - v;
                p[1] = (r == 8'h00);
                p[7] = r[7];
            end
            O_CPX:
            begin
                p[0] = (x >= v);
                r = x - v;
                p[1] = (r == 8'h00);
                p[7] = r[7];
            end
            O_CPY:
            begin
                p[0] = (y >= v);
                r = y - v;
                p[1] = (r == 8'h00);
                p[7] = r[7];
            end
            O_BIT:
            begin
                p[1] = ((a & v) == 8'h00);
                p[7] = v[7];
                p[6] = v[6];
            end
            O_LDA:
            begin
                a = v;
                p[1] = (a == 8'h00);
                p[7] = a[7];
            end
            O_LDX:
            begin
                x = v;
                p[1] = (x == 8'h00);
                p[7] = x[7];
            end
            O_LDY:
            begin
                y = v;
                p[1] = (y == 8'h00);
                p[7] = y[7];
            end
            O_LAX:
            begin
                a = v;
                x = v;
                p[1] = (v == 8'h00);
                p[7] = v[7];
            end
            O_STA, O_STX, O_STY, O_SAX:
            begin
                if (code == O_STA)
                    r = a;
                else if (code == O_STX)
                    r = x;
                else if (code == O_STY)
                    r = y;
                else
                    r = a & x;
                if (mode_a)
                    a = r;
                else
                begin
                    we = 1'b1;
                    wv = r;
                end
            end
            O_TAX:
            begin
                x = a;
                p[1] = (x == 8'h00);
                p[7] = x[7];
            end
            O_TAY:
            begin
                y = a;
                p[1] = (y == 8'h00);
                p[7] = y[7];
            end
            O_TXA:
            begin
                a = x;
                p[1] = (a == 8'h00);
                p[7] = a[7];
            end
            O_TYA:
            begin
                a = y;
                p[1] = (a == 8'h00);
                p[7] = a[7];
            end
            O_TSX:
            begin
                x = sp;
                p[1] = (x == 8'h00);
                p[7] = x[7];
            end
            O_TXS: sp = x;
            O_INX:
            begin
                x = x + 8'd1;
                p[1] = (x == 8'h00);
                p[7] = x[7];
            end
            O_INY:
            begin
                y = y + 8'd1;
                p[1] = (y == 8'h00);
                p[7] = y[7];
            end
            O_DEX:
            begin
                x = x - 8'd1;
                p[1] = (x == 8'h00);
                p[7] = x[7];
            end
            O_DEY:
            begin
                y = y - 8'd1;
                p[1] = (y == 8'h00);
                p[7] = y[7];
            end
            O_CLC: p[0] = 1'b0;
            O_SEC: p[0] = 1'b1;
            O_CLI: p[2] = 1'b0;
            O_SEI: p[2] = 1'b1;
            O_CLV: p[6] = 1'b0;
            O_CLD: p[3] = 1'b0;
            O_SED: p[3] = 1'b1;
            default: ;
        endcase

        result.store_value  = wv;
        result.store_enable = we;
        result.regs.a       = a;
        result.regs.x       = x;
        result.regs.y       = y;
        result.regs.sp      = sp;
        result.regs.p       = p;
        result.handled      = (code != O_XX);
    end

endmodule

`default_nettype wire

// File: sv/cpu8_register_alu_execute_unit.sv
// top level: instruction register, execute logic, register file and result register
//
// Executes the data part of one 6502-style instruction per item: the opcode
// and its already fetched operand byte enter an input register, the execute
// logic works from that register and the current A, X, Y, SP and status, and
// the result item (store byte, store enable, all registers, handled flag) is
// held in an output register while the register file takes the new values.
// An accepted item passes the input register, then the output register; a new item
// is taken every cycle while not stalled; the throughput is set by the single pass
// through the execute logic between the input and output registers. A full output
// register that is not taken stalls the input register, dropping in_ch.ready. The
// user must write the decimal_enable bit (cfg_wr_en/cfg_wr_data) only while idle
// (not enforced by the block); it allows BCD add and subtract when status D is set.
`default_nettype none

module cpu8_register_alu_execute_unit
    import cpu8_rae_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    cpu8_rae_in_if.sink     in_ch,
    cpu8_rae_out_if.source  out_ch,
    input  wire logic       cfg_wr_en,
    input  wire logic [0:0] cfg_wr_data
);

    logic       in_valid_reg;
    logic [7:0] op_reg;
    logic [7:0] operand_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    regs_t      regs_reg;
    logic       decimal_enable_reg;
    result_t    result_next;
    logic       exec_fire;

    assign exec_fire   = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || exec_fire;

    cpu8_rae_alu u_alu (
        .op             (op_reg),
        .operand        (operand_reg),
        .decimal_enable (decimal_enable_reg),
        .regs_in        (regs_reg),
        .result         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            decimal_enable_reg <= 1'b0;
            regs_reg.a         <= 8'h00;
            regs_reg.x         <= 8'h00;
            regs_reg.y         <= 8'h00;
            regs_reg.sp        <= SP_RESET;
            regs_reg.p         <= STATUS_RESET;
        end
        else
        begin
            if (cfg_wr_en)
                decimal_enable_reg <= cfg_wr_data[0];
            if (in_ch.ready)
                in_valid_reg <= in_ch.valid;
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
                regs_reg      <= result_next.regs;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            op_reg      <= in_ch.op;
            operand_reg <= in_ch.operand;
        end
        if (exec_fire)
            out_reg <= result_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.store_value  = out_reg.store_value;
    assign out_ch.store_enable = out_reg.store_enable;
    assign out_ch.reg_a        = out_reg.regs.a;
    assign out_ch.reg_x        = out_reg.regs.x;
    assign out_ch.reg_y        = out_reg.regs.y;
    assign out_ch.stack_ptr    = out_reg.regs.sp;
    assign out_ch.status_flags = out_reg.regs.p;
    assign out_ch.handled      = out_reg.handled;

    a_const_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.regs.p[5])
        else $error("status constant bit clear in result");

    a_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.store_enable) |-> (out_reg.store_value == 8'h00))
        else $error("store value nonzero without store");

    a_unhandled_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.handled) |-> !out_reg.store_enable)
        else $error("store requested for unhandled opcode");

    a_regs_track: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.regs == regs_reg))
        else $error("register file differs from latest result");

endmodule

`default_nettype wire

// File: verif/tb_cpu8_register_alu_execute_unit.sv
// testbench: predicts each result item from the opcode and operand and checks the unit's output
`default_nettype none

class cpu8_exec_scoreboard;
    logic [7:0] acc, ix, iy, sp, ps;
    logic       dec_en;
    logic [7:0] exp_q[$];
    logic [55:0] want_q[$];
    int errors;

    function new();
        acc = 0; ix = 0; iy = 0; sp = 8'hfd; ps = 8'h20; dec_en = 0; errors = 0;
    endfunction

    function void setf(logic [7:0] m, bit on);
        if (on) ps = ps | m;
        else ps = ps & ~m;
    endfunction

    function void nz(logic [15:0] r);
        setf(8'h02, r[7:0] == 0);
        setf(8'h80, r[7]);
    endfunction

    function void add_acc(logic [7:0] v);
        logic [15:0] r;
        logic [7:0] a;
        logic [4:0] c;
        a = acc;
        c = {4'b0, ps[0]};
        r = v + a + c;
        setf(8'h02, r[7:0] == 0);
        if (ps[3] && dec_en) begin
            if ({1'b0, a[3:0]} + {1'b0, v[3:0]} + c > 9) r = r + 16'd6;
            setf(8'h80, r[7]);
            setf(8'h40, (~(a ^ v) & (a ^ r[7:0]) & 8'h80) != 0);
            if (r > 16'h99) r = r + 16'h60;
            setf(8'h01, r > 16'h99);
        end
        else begin
            setf(8'h80, r[7]);
            setf(8'h40, (~(a ^ v) & (a ^ r[7:0]) & 8'h80) != 0);
            setf(8'h01, r[8]);
        end
        acc = r[7:0];
    endfunction

    function void sub_acc(logic [7:0] v);
        logic [15:0] r;
        logic [7:0] a;
        int lo, b;
        a = acc;
        b = ps[0] ? 0 : 1;
        r = {8'b0, a} - {8'b0, v} - 16'(b);
        nz(r);
        setf(8'h40, ((a ^ r[7:0]) & 8'h80) != 0 && ((a ^ v) & 8'h80) != 0);
        if (ps[3] && dec_en) begin
            lo = int'(a[3:0]) - b;
            if (lo < int'(v[3:0])) r = r - 16'd6;
            if (r > 16'h99) r = r - 16'h60;
        end
        setf(8'h01, r < 16'h100);
        acc = r[7:0];
    endfunction

    function void cmp_reg(logic [7:0] rg, logic [7:0] v);
        setf(8'h01, rg >= v);
        nz({8'b0, rg} - {8'b0, v});
    endfunction

    function void note_item(logic [7:0] op, logic [7:0] operand);
        cpu8_rae_pkg::op_class_t k;
        bit am, we;
        logic [7:0] m, wv, v;
        logic [8:0] r;
        k = cpu8_rae_pkg::DECODE_TABLE[op];
        am = (op[3:0] == 8 || op[3:0] == 10) ||
             (op[3:0] == 2 && (op[4] || op[7:4] < 8)) ||
             (op == 8'h00 || op == 8'h40 || op == 8'h60);
        m = operand; we = 0; wv = 0;
        ps = ps | 8'h20;
        v = am ? acc : m;
        case (k)
            cpu8_rae_pkg::O_ASL, cpu8_rae_pkg::O_SLO: r = {v, 1'b0};
            cpu8_rae_pkg::O_ROL, cpu8_rae_pkg::O_RLA: r = {v, ps[0]};
            cpu8_rae_pkg::O_LSR, cpu8_rae_pkg::O_SRE: r = {1'b0, 1'b0, v[7:1]};
            cpu8_rae_pkg::O_ROR, cpu8_rae_pkg::O_RRA: r = {1'b0, ps[0], v[7:1]};
            cpu8_rae_pkg::O_INC, cpu8_rae_pkg::O_ISB: r = {1'b0, v + 8'd1};
            cpu8_rae_pkg::O_DEC, cpu8_rae_pkg::O_DCP: r = {1'b0, v - 8'd1};
            cpu8_rae_pkg::O_STA: r = {1'b0, acc};
            cpu8_rae_pkg::O_STX: r = {1'b0, ix};
            cpu8_rae_pkg::O_STY: r = {1'b0, iy};
            cpu8_rae_pkg::O_SAX: r = {1'b0, acc & ix};
            default: r = 0;
        endcase
        case (k)
            cpu8_rae_pkg::O_ASL, cpu8_rae_pkg::O_SLO, cpu8_rae_pkg::O_ROL,
            cpu8_rae_pkg::O_RLA: setf(8'h01, r[8]);
            cpu8_rae_pkg::O_LSR, cpu8_rae_pkg::O_SRE, cpu8_rae_pkg::O_ROR,
            cpu8_rae_pkg::O_RRA: setf(8'h01, v[0]);
            default: ;
        endcase
        case (k)
            cpu8_rae_pkg::O_ASL, cpu8_rae_pkg::O_SLO, cpu8_rae_pkg::O_ROL,
            cpu8_rae_pkg::O_RLA, cpu8_rae_pkg::O_LSR, cpu8_rae_pkg::O_SRE,
            cpu8_rae_pkg::O_ROR, cpu8_rae_pkg::O_RRA, cpu8_rae_pkg::O_INC,
            cpu8_rae_pkg::O_ISB, cpu8_rae_pkg::O_DEC, cpu8_rae_pkg::O_DCP,
            cpu8_rae_pkg::O_STA, cpu8_rae_pkg::O_STX, cpu8_rae_pkg::O_STY,
            cpu8_rae_pkg::O_SAX:
            begin
                if (!(k inside {cpu8_rae_pkg::O_STA, cpu8_rae_pkg::O_STX,
                                cpu8_rae_pkg::O_STY, cpu8_rae_pkg::O_SAX}))
                    nz({8'b0, r[7:0]});
                if (am) acc = r[7:0];
                else begin m = r[7:0]; we = 1; wv = r[7:0]; end
            end
            default: ;
        endcase
        v = am ? acc : m;
        case (k)
            cpu8_rae_pkg::O_ORA, cpu8_rae_pkg::O_SLO: begin acc = acc | v; nz({8'b0, acc}); end
            cpu8_rae_pkg::O_AND, cpu8_rae_pkg::O_RLA: begin acc = acc & v; nz({8'b0, acc}); end
            cpu8_rae_pkg::O_EOR, cpu8_rae_pkg::O_SRE: begin acc = acc ^ v; nz({8'b0, acc}); end
            cpu8_rae_pkg::O_ADC, cpu8_rae_pkg::O_RRA: add_acc(v);
            cpu8_rae_pkg::O_SBC, cpu8_rae_pkg::O_ISB: sub_acc(v);
            cpu8_rae_pkg::O_CMP, cpu8_rae_pkg::O_DCP: cmp_reg(acc, v);
            cpu8_rae_pkg::O_CPX: cmp_reg(ix, v);
            cpu8_rae_pkg::O_CPY: cmp_reg(iy, v);
            cpu8_rae_pkg::O_BIT:
            begin
                setf(8'h02, (acc & v) == 0);
                setf(8'h80, v[7]);
                setf(8'h40, v[6]);
            end
            cpu8_rae_pkg::O_LDA: begin acc = v; nz({8'b0, v}); end
            cpu8_rae_pkg::O_LDX: begin ix = v; nz({8'b0, v}); end
            cpu8_rae_pkg::O_LDY: begin iy = v; nz({8'b0, v}); end
            cpu8_rae_pkg::O_LAX: begin acc = v; ix = v; nz({8'b0, v}); end
            cpu8_rae_pkg::O_TAX: begin ix = acc; nz({8'b0, ix}); end
            cpu8_rae_pkg::O_TAY: begin iy = acc; nz({8'b0, iy}); end
            cpu8_rae_pkg::O_TXA: begin acc = ix; nz({8'b0, acc}); end
            cpu8_rae_pkg::O_TYA: begin acc = iy; nz({8'b0, acc}); end
            cpu8_rae_pkg::O_TSX: begin ix = sp; nz({8'b0, ix}); end
            cpu8_rae_pkg::O_TXS: sp = ix;
            cpu8_rae_pkg::O_INX: begin ix = ix + 8'd1; nz({8'b0, ix}); end
            cpu8_rae_pkg::O_INY: begin iy = iy + 8'd1; nz({8'b0, iy}); end
            cpu8_rae_pkg::O_DEX: begin ix = ix - 8'd1; nz({8'b0, ix}); end
            cpu8_rae_pkg::O_DEY: begin iy = iy - 8'd1; nz({8'b0, iy}); end
            cpu8_rae_pkg::O_CLC: setf(8'h01, 0);
            cpu8_rae_pkg::O_SEC: setf(8'h01, 1);
            cpu8_rae_pkg::O_CLI: setf(8'h04, 0);
            cpu8_rae_pkg::O_SEI: setf(8'h04, 1);
            cpu8_rae_pkg::O_CLV: setf(8'h40, 0);
            cpu8_rae_pkg::O_CLD: setf(8'h08, 0);
            cpu8_rae_pkg::O_SED: setf(8'h08, 1);
            default: ;
        endcase
        want_q.push_back({wv, 6'b0, we, k != cpu8_rae_pkg::O_XX, acc, ix, iy, sp, ps});
        exp_q.push_back(op);
    endfunction

    function void check_result(time t, logic [7:0] sv, logic se, logic [7:0] a,
                               logic [7:0] x, logic [7:0] y, logic [7:0] s,
                               logic [7:0] p, logic h);
        logic [55:0] w, got;
        logic [7:0] op;
        got = {sv, 6'b0, se, h, a, x, y, s, p};
        if (want_q.size() == 0) begin
            $display("%0t unexpected result item %h", t, got);
            errors++;
            return;
        end
        w = want_q.pop_front();
        op = exp_q.pop_front();
        if (w !== got) begin
            $display("%0t op %h: expected sv=%h se=%b h=%b a=%h x=%h y=%h sp=%h p=%h",
                     t, op, w[55:48], w[41], w[40], w[39:32], w[31:24], w[23:16],
                     w[15:8], w[7:0]);
            $display("%0t op %h:   actual sv=%h se=%b h=%b a=%h x=%h y=%h sp=%h p=%h",
                     t, op, sv, se, h, a, x, y, s, p);
            errors++;
        end
    endfunction
endclass

module tb_cpu8_register_alu_execute_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk, rst_n, cfg_wr_en;
    logic [0:0] cfg_wr_data;
    int src_idle, snk_idle, quiet;
    cpu8_exec_scoreboard sb;

    cpu8_rae_in_if in_ch();
    cpu8_rae_out_if out_ch();

    cpu8_register_alu_execute_unit uut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        sb = new();
        rst_n = 0; cfg_wr_en = 0; cfg_wr_data = 0;
        in_ch.valid = 0; in_ch.op = 0; in_ch.operand = 0; out_ch.ready = 0;
        src_idle = 0; snk_idle = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ch.ready <= ($urandom_range(99) >= snk_idle);
            if (out_ch.valid && out_ch.ready)
                sb.check_result($time, out_ch.store_value, out_ch.store_enable,
                                out_ch.reg_a, out_ch.reg_x, out_ch.reg_y,
                                out_ch.stack_ptr, out_ch.status_flags, out_ch.handled);
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
        else quiet++;
        if (quiet > 5000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(logic [7:0] op, logic [7:0] operand);
        while ($urandom_range(99) < src_idle)
        begin
            in_ch.valid <= 0;
            @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.op <= op;
        in_ch.operand <= operand;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_item(op, operand);
    endtask

    task automatic set_decimal(logic val);
        in_ch.valid <= 0;
        @(posedge clk);
        while (sb.want_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 0;
        sb.dec_en = val;
    endtask

    function automatic logic [7:0] pick_op();
        case ($urandom_range(5))
            0: return 8'h69;
            1: return 8'he9;
            2: return $urandom_range(1) ? 8'hf8 : 8'hd8;
            3: return $urandom_range(1) ? 8'h38 : 8'h18;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial
    begin
        logic [7:0] dir_op [22];
        logic [7:0] dir_val [22];
        dir_op = '{8'ha9, 8'ha2, 8'ha0, 8'h0a, 8'h2a, 8'h4a, 8'h6a, 8'h69, 8'he9, 8'hc9,
                   8'h24, 8'h87, 8'h07, 8'h27, 8'h47, 8'h67, 8'hc7, 8'he7, 8'h9a, 8'hba,
                   8'h4c, 8'hea};
        dir_val = '{8'hff, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7f, 8'h80, 8'hff,
                    8'hc0, 8'h00, 8'h81, 8'h7e, 8'h01, 8'hff, 8'h00, 8'hff, 8'h00, 8'h00,
                    8'h55, 8'haa};
        @(posedge rst_n);
        @(posedge clk);
        src_idle = 35; snk_idle = 84;
        set_decimal(1);
        foreach (dir_op[i]) send_item(dir_op[i], dir_val[i]);
        send_item(8'hf8, 8'h00);
        send_item(8'h69, 8'h99);
        send_item(8'he9, 8'h01);
        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle = (ph == 0) ? 35 : (ph == 1) ? 84 : 0;
            snk_idle = (ph == 0) ? 84 : (ph == 1) ? 35 : 0;
            set_decimal(ph != 1);
            for (int i = 0; i < 150; i++) send_item(pick_op(), 8'($urandom_range(255)));
        end
        in_ch.valid <= 0;
        while (sb.want_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule

`default_nettype wire

// File: filelist.f
sv/cpu8_rae_pkg.sv
sv/cpu8_rae_if.sv
sv/cpu8_rae_alu.sv
sv/cpu8_register_alu_execute_unit.sv
verif/tb_cpu8_register_alu_execute_unit.sv
